FILE: src/cto_pkg.sv
// Package: types, constants and cause codes for the circle/triangle overlap core.
package cto_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;

  // Cause codes
  localparam logic [2:0] CAUSE_NONE   = 3'd0;
  localparam logic [2:0] CAUSE_CENTRE = 3'd1;
  localparam logic [2:0] CAUSE_AB     = 3'd2;
  localparam logic [2:0] CAUSE_AC     = 3'd3;
  localparam logic [2:0] CAUSE_BC     = 3'd4;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] ax;
    logic signed [COORD_WIDTH_DEF-1:0] ay;
    logic signed [COORD_WIDTH_DEF-1:0] bx;
    logic signed [COORD_WIDTH_DEF-1:0] by;
    logic signed [COORD_WIDTH_DEF-1:0] cx;
    logic signed [COORD_WIDTH_DEF-1:0] cy;
  } tri_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] cause;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]       index;
    logic [COORD_WIDTH_DEF-1:0] data;
  } cfg_t;

  // Per-edge flags that travel down the pipe
  typedef struct packed {
    logic degen;
    logic near_end;
    logic proj_in;
  } edge_flags_t;

endpackage

FILE: src/cto_edge.sv
// One triangle edge test, pipelined: endpoint, projection and foot-distance checks.
module cto_edge #(
  parameter int unsigned W = cto_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] px,
  input  logic signed [W-1:0] py,
  input  logic signed [W-1:0] qx,
  input  logic signed [W-1:0] qy,
  input  logic signed [W-1:0] ox,
  input  logic signed [W-1:0] oy,
  input  logic [2*W-3:0]      rr,
  output logic                hit
);
  localparam int unsigned DW = W + 1;        // coordinate differences
  localparam int unsigned PW = 2 * DW + 1;   // sums of two products
  localparam int unsigned SW = 2 * PW;       // cross^2 and rr*l
  localparam int unsigned HW = (PW + 1) / 2; // halves for the wide products
  localparam int unsigned RW = 2 * W - 2;    // rr width

  // Stage 1: differences
  logic signed [DW-1:0] s1_dx, s1_dy, s1_ex, s1_ey, s1_fx, s1_fy;
  logic                 s1_degen;
  // Stage 2: products
  logic signed [2*DW-1:0] s2_pp0, s2_pp1, s2_qq0, s2_qq1, s2_ll0, s2_ll1;
  logic signed [2*DW-1:0] s2_dd0, s2_dd1, s2_cc0, s2_cc1;
  logic                   s2_degen;
  // Stage 3: sums and compares
  logic signed [PW-1:0] s3_l, s3_cr;
  cto_pkg::edge_flags_t s3_f;
  // Stage 4: partial products of cross^2 and rr*l
  logic [2*HW-1:0]      s4_sq_ll, s4_sq_lh, s4_sq_hh;
  logic [RW+HW-1:0]     s4_rl_lo, s4_rl_hi;
  cto_pkg::edge_flags_t s4_f;
  // Stage 5: wide sums
  logic [SW-1:0]        s5_cr2, s5_rrl;
  cto_pkg::edge_flags_t s5_f;

  logic signed [PW-1:0] r1, r2, dl;
  logic signed [PW:0]   rr_s;
  logic [PW-1:0]        cr_abs, l_u;
  logic [HW-1:0]        cr_lo, cr_hi, l_lo, l_hi;

  assign r1   = PW'(s2_pp0) + PW'(s2_pp1);
  assign r2   = PW'(s2_qq0) + PW'(s2_qq1);
  assign dl   = PW'(s2_dd0) + PW'(s2_dd1);
  assign rr_s = (PW + 1)'(rr);

  // squares are non-negative; split magnitudes into halves
  assign cr_abs = unsigned'(s3_cr[PW-1] ? -s3_cr : s3_cr);
  assign l_u    = unsigned'(s3_l);
  assign cr_lo  = cr_abs[HW-1:0];
  assign cr_hi  = HW'(cr_abs[PW-1:HW]);
  assign l_lo   = l_u[HW-1:0];
  assign l_hi   = HW'(l_u[PW-1:HW]);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx    <= DW'(qx) - DW'(px);
      s1_dy    <= DW'(qy) - DW'(py);
      s1_ex    <= DW'(ox) - DW'(px);
      s1_ey    <= DW'(oy) - DW'(py);
      s1_fx    <= DW'(qx) - DW'(ox);
      s1_fy    <= DW'(qy) - DW'(oy);
      s1_degen <= (px == qx) && (py == qy);

      s2_pp0   <= s1_ex * s1_ex;
      s2_pp1   <= s1_ey * s1_ey;
      s2_qq0   <= s1_fx * s1_fx;
      s2_qq1   <= s1_fy * s1_fy;
      s2_ll0   <= s1_dx * s1_dx;
      s2_ll1   <= s1_dy * s1_dy;
      s2_dd0   <= s1_dx * s1_ex;
      s2_dd1   <= s1_dy * s1_ey;
      s2_cc0   <= s1_dx * s1_ey;
      s2_cc1   <= s1_dy * s1_ex;
      s2_degen <= s1_degen;

      s3_l          <= PW'(s2_ll0) + PW'(s2_ll1);
      s3_cr         <= PW'(s2_cc0) - PW'(s2_cc1);
      s3_f.degen    <= s2_degen;
      s3_f.near_end <= ((PW + 1)'(r1) < rr_s) || ((PW + 1)'(r2) < rr_s);
      s3_f.proj_in  <= (dl > 0) && (dl < (PW'(s2_ll0) + PW'(s2_ll1)));

      s4_sq_ll <= cr_lo * cr_lo;
      s4_sq_lh <= cr_lo * cr_hi;
      s4_sq_hh <= cr_hi * cr_hi;
      s4_rl_lo <= rr * l_lo;
      s4_rl_hi <= rr * l_hi;
      s4_f     <= s3_f;

      // cross term appears twice in the square
      s5_cr2 <= (SW'(s4_sq_hh) << (2 * HW)) + (SW'(s4_sq_lh) << (HW + 1)) + SW'(s4_sq_ll);
      s5_rrl <= (SW'(s4_rl_hi) << HW) + SW'(s4_rl_lo);
      s5_f   <= s4_f;

      hit <= !s5_f.degen && (s5_f.near_end || (s5_f.proj_in && (s5_cr2 < s5_rrl)));
    end
  end

endmodule

FILE: src/circle_triangle_overlap_core.sv
// Circle vs triangle overlap: centre-inside test plus edge tests on AB, AC, BC.
// Accepts one item per cycle while the output is not stalled.
// The output register is the last pipeline stage; the pipe advances whenever
// that stage is empty or being taken, so a stall holds all stages.
// Reset (rst, synchronous) clears pipeline valid bits and the circle registers.
module circle_triangle_overlap_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cto_pkg::tri_t       in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cto_pkg::res_t       out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cto_pkg::cfg_t       cfg
);
  localparam int unsigned W   = cto_pkg::COORD_WIDTH_DEF;
  localparam int unsigned DW  = W + 1;
  localparam int unsigned PW  = 2 * DW + 1;
  localparam int unsigned NST = 6;

  // Configuration registers
  logic signed [W-1:0] centre_x, centre_y;
  logic [W-2:0]        radius;
  logic [2*W-3:0]      rr;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x <= '0;
      centre_y <= '0;
      radius   <= '0;
    end else if (cfg_valid) begin
      case (cfg.index)
        cto_pkg::REG_CENTRE_X: centre_x <= W'(cfg.data);
        cto_pkg::REG_CENTRE_Y: centre_y <= W'(cfg.data);
        cto_pkg::REG_RADIUS:   radius   <= (W - 1)'(cfg.data);
        default: ;
      endcase
    end
  end
  assign rr = radius * radius;

  // Pipeline control
  logic [NST-1:0] vld;
  logic           adv;
  assign adv       = !vld[NST-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NST-2:0], in_valid};
  end

  logic signed [W-1:0] ax, ay, bx, by, cx, cy;
  assign ax = W'(in_item.ax);
  assign ay = W'(in_item.ay);
  assign bx = W'(in_item.bx);
  assign by = W'(in_item.by);
  assign cx = W'(in_item.cx);
  assign cy = W'(in_item.cy);

  // Centre test: stage 1 differences
  logic signed [DW-1:0] c1_ux, c1_uy, c1_vx, c1_vy, c1_wx, c1_wy;
  // stage 2 products
  logic signed [2*DW-1:0] c2_d0, c2_d1, c2_s0, c2_s1, c2_t0, c2_t1;
  // stage 3 determinants
  logic signed [PW-1:0] c3_d, c3_s, c3_t;
  // stage 4 inside flag, stages 5 and 6 carry it
  logic c4_in;

  logic signed [PW-1:0] dd, ds, dt;
  logic signed [PW:0]   st;
  assign dd = PW'(c2_d0) - PW'(c2_d1);
  assign ds = PW'(c2_s0) - PW'(c2_s1);
  assign dt = PW'(c2_t0) - PW'(c2_t1);
  assign st = (PW + 1)'(c3_s) + (PW + 1)'(c3_t);

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_ux <= DW'(bx) - DW'(ax);
      c1_uy <= DW'(by) - DW'(ay);
      c1_vx <= DW'(cx) - DW'(ax);
      c1_vy <= DW'(cy) - DW'(ay);
      c1_wx <= DW'(centre_x) - DW'(ax);
      c1_wy <= DW'(centre_y) - DW'(ay);

      c2_d0 <= c1_ux * c1_vy;
      c2_d1 <= c1_uy * c1_vx;
      c2_s0 <= c1_wx * c1_vy;
      c2_s1 <= c1_wy * c1_vx;
      c2_t0 <= c1_ux * c1_wy;
      c2_t1 <= c1_uy * c1_wx;

      // sign-normalize
      c3_d <= dd[PW-1] ? -dd : dd;
      c3_s <= dd[PW-1] ? -ds : ds;
      c3_t <= dd[PW-1] ? -dt : dt;

      c4_in <= (c3_s >= 0) && (c3_t >= 0) && (st <= (PW + 1)'(c3_d));
    end
  end

  // Edge units
  logic hit_ab, hit_ac, hit_bc;
  cto_edge #(.W(W)) u_ab (.clk, .en(adv), .px(ax), .py(ay), .qx(bx), .qy(by),
    .ox(centre_x), .oy(centre_y), .rr, .hit(hit_ab));
  cto_edge #(.W(W)) u_ac (.clk, .en(adv), .px(ax), .py(ay), .qx(cx), .qy(cy),
    .ox(centre_x), .oy(centre_y), .rr, .hit(hit_ac));
  cto_edge #(.W(W)) u_bc (.clk, .en(adv), .px(bx), .py(by), .qx(cx), .qy(cy),
    .ox(centre_x), .oy(centre_y), .rr, .hit(hit_bc));

  // Stage 6: priority pick, centre flag delayed to line up
  logic c5_in, c6_in;
  always_ff @(posedge clk) begin
    if (adv) begin
      c5_in <= c4_in;
      c6_in <= c5_in;
    end
  end

  always_comb begin
    if (c6_in)       out_item.cause = cto_pkg::CAUSE_CENTRE;
    else if (hit_ab) out_item.cause = cto_pkg::CAUSE_AB;
    else if (hit_ac) out_item.cause = cto_pkg::CAUSE_AC;
    else if (hit_bc) out_item.cause = cto_pkg::CAUSE_BC;
    else             out_item.cause = cto_pkg::CAUSE_NONE;
    out_item.hit = (out_item.cause != cto_pkg::CAUSE_NONE);
  end

  // A stalled output must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed under stall");
  // Valid bits only shift when the pipe advances
  a_vld: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");
  // Hit follows cause
  a_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.hit == (out_item.cause != cto_pkg::CAUSE_NONE)))
    else $error("hit and cause disagree");

endmodule
